### sv/tis_pkg.sv
// Package for the Telnet item segmenter: codes, parse phases, word types.
// Used by tis_parser, tis_out_queue and telnet_item_segmenter_unit.
// No dependencies.
package tis_pkg;

  // Telnet command codes
  localparam logic [7:0] CODE_IAC  = 8'hff;
  localparam logic [7:0] CODE_DONT = 8'hfe;
  localparam logic [7:0] CODE_DO   = 8'hfd;
  localparam logic [7:0] CODE_WONT = 8'hfc;
  localparam logic [7:0] CODE_WILL = 8'hfb;
  localparam logic [7:0] CODE_SB   = 8'hfa;
  localparam logic [7:0] CODE_EL   = 8'hf8;
  localparam logic [7:0] CODE_EC   = 8'hf7;
  localparam logic [7:0] CODE_SE   = 8'hf0;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_HELD    = 3'd2,
    PH_OPTION  = 3'd3,
    PH_SUB     = 3'd4,
    PH_SUB_IAC = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_NEG  = 2'd2,
    KIND_SUB  = 2'd3
  } kind_t;

  // One output word
  typedef struct packed {
    logic [7:0] byte_val;
    logic       item_start;
    kind_t      item_kind;
    logic       last_of_run;
  } result_t;

  // Words produced by one accepted input byte (zero, one or two)
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### sv/telnet_item_segmenter_unit.sv
// Top level of the Telnet item segmenter.
// Depends on tis_pkg, tis_parser and tis_out_queue.
// Splits a Telnet byte stream into data, command, negotiation and subnegotiation items.
//
// Usage:
//   Input channel: byte_in with in_valid / in_stall; a word is taken at a rising
//   edge with in_valid high and in_stall low. One byte per clock is taken while in_stall is low.
//   Output channel: byte_out, item_start, item_kind, last_of_run with out_valid /
//   out_stall; a word leaves at an edge with out_valid high and out_stall low.
//   Each input byte gives zero, one or two output words; two only when a held
//   IAC is released with the byte after it, which itself gave none.
//   With the queue empty, a byte's first word is on the output the cycle after
//   the byte is taken; the second word of a pair follows once the first has left.
//   Throughput: one byte per clock while in_stall is low, limited by the
//   one-word-per-clock output port of a four-word result queue; in_stall rises
//   when more than two words are waiting, so a stalled receiver backs up the input.
//   cfg_we / cfg_wdata write synch_clear (drop data and erase commands);
//   write it only while the block is idle.
//   Reset (rst, synchronous): queue empty, parser between items, synch_clear 0.
module telnet_item_segmenter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic       item_start,
  output logic [1:0] item_kind,
  output logic       last_of_run
);

  logic             synch_clear;
  logic             accept;
  logic             pop;
  logic             nearly_full;
  tis_pkg::push_t   push;
  tis_pkg::result_t head;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      synch_clear <= 1'b0;
    end else if (cfg_we) begin
      synch_clear <= cfg_wdata;
    end
  end

  // Handshakes
  assign in_stall = nearly_full;
  assign accept   = in_valid & ~in_stall;
  assign pop      = out_valid & ~out_stall;

  tis_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_in     (byte_in),
    .synch_clear (synch_clear),
    .push        (push)
  );

  tis_out_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pop         (pop),
    .head        (head),
    .not_empty   (out_valid),
    .nearly_full (nearly_full)
  );

  assign byte_out    = head.byte_val;
  assign item_start  = head.item_start;
  assign item_kind   = head.item_kind;
  assign last_of_run = head.last_of_run;

  // Input is only held off while words wait at the output
  a_stall_has_words: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // A taken byte that yields words shows one at the output next cycle
  a_word_follows: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |=> out_valid)
    else $error("pushed word not visible");

  // A data item start word is always the last word of its byte
  a_start_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_start && item_kind == tis_pkg::KIND_DATA |-> last_of_run)
    else $error("data item start not final word of its byte");

endmodule

### sv/tis_parser.sv
// Telnet stream parser: phase state, drop decision and word generation.
// Depends on tis_pkg.
// Produces up to two words per accepted byte for the result queue.
module tis_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     byte_in,
  input  logic           synch_clear,
  output tis_pkg::push_t push
);

  tis_pkg::phase_t phase, phase_next;
  tis_pkg::kind_t  cur_kind, cur_kind_next;
  logic            dropping, dropping_next;

  logic is_neg;
  logic is_erase;
  tis_pkg::kind_t held_kind;
  logic held_drop;

  assign is_neg = (byte_in == tis_pkg::CODE_DO)   || (byte_in == tis_pkg::CODE_DONT) ||
                  (byte_in == tis_pkg::CODE_WILL) || (byte_in == tis_pkg::CODE_WONT);
  assign is_erase = (byte_in == tis_pkg::CODE_EC) || (byte_in == tis_pkg::CODE_EL);

  // Kind of a command once its second byte is seen
  always_comb begin
    if (is_neg) begin
      held_kind = tis_pkg::KIND_NEG;
      held_drop = 1'b0;
    end else if (byte_in == tis_pkg::CODE_SB) begin
      held_kind = tis_pkg::KIND_SUB;
      held_drop = 1'b0;
    end else begin
      held_kind = tis_pkg::KIND_CMD;
      held_drop = synch_clear & is_erase;
    end
  end

  // Next phase and words for this byte
  always_comb begin
    phase_next    = phase;
    cur_kind_next = cur_kind;
    dropping_next = dropping;
    push          = '0;
    unique case (phase)
      tis_pkg::PH_HELD: begin
        cur_kind_next = held_kind;
        dropping_next = held_drop;
        if (is_neg) begin
          phase_next = tis_pkg::PH_OPTION;
        end else if (byte_in == tis_pkg::CODE_SB) begin
          phase_next = tis_pkg::PH_SUB;
        end else begin
          phase_next = tis_pkg::PH_IDLE;
        end
        if (!held_drop) begin
          push.cnt = 2'd2;
          push.r0  = '{byte_val: tis_pkg::CODE_IAC, item_start: 1'b1,
                       item_kind: held_kind, last_of_run: 1'b0};
          push.r1  = '{byte_val: byte_in, item_start: 1'b0,
                       item_kind: held_kind, last_of_run: 1'b1};
        end
      end
      tis_pkg::PH_OPTION: begin
        push.cnt   = 2'd1;
        push.r0    = '{byte_val: byte_in, item_start: 1'b0,
                       item_kind: cur_kind, last_of_run: 1'b1};
        phase_next = tis_pkg::PH_IDLE;
      end
      tis_pkg::PH_SUB: begin
        push.cnt = 2'd1;
        push.r0  = '{byte_val: byte_in, item_start: 1'b0,
                     item_kind: cur_kind, last_of_run: 1'b1};
        if (byte_in == tis_pkg::CODE_IAC) begin
          phase_next = tis_pkg::PH_SUB_IAC;
        end
      end
      tis_pkg::PH_SUB_IAC: begin
        push.cnt   = 2'd1;
        push.r0    = '{byte_val: byte_in, item_start: 1'b0,
                       item_kind: cur_kind, last_of_run: 1'b1};
        phase_next = (byte_in == tis_pkg::CODE_SE) ? tis_pkg::PH_IDLE : tis_pkg::PH_SUB;
      end
      tis_pkg::PH_DATA: begin
        if (byte_in == tis_pkg::CODE_IAC) begin
          phase_next = tis_pkg::PH_HELD;
        end else if (!dropping) begin
          push.cnt = 2'd1;
          push.r0  = '{byte_val: byte_in, item_start: 1'b0,
                       item_kind: tis_pkg::KIND_DATA, last_of_run: 1'b1};
        end
      end
      default: begin
        // between items; unused codes behave the same
        if (byte_in == tis_pkg::CODE_IAC) begin
          phase_next = tis_pkg::PH_HELD;
        end else begin
          cur_kind_next = tis_pkg::KIND_DATA;
          dropping_next = synch_clear;
          phase_next    = tis_pkg::PH_DATA;
          if (!synch_clear) begin
            push.cnt = 2'd1;
            push.r0  = '{byte_val: byte_in, item_start: 1'b1,
                         item_kind: tis_pkg::KIND_DATA, last_of_run: 1'b1};
          end
        end
      end
    endcase
    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= tis_pkg::PH_IDLE;
      cur_kind <= tis_pkg::KIND_DATA;
      dropping <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      cur_kind <= cur_kind_next;
      dropping <= dropping_next;
    end
  end

  // A pair of words only ever releases a held IAC
  a_pair_from_held: assert property (@(posedge clk) disable iff (rst)
    push.cnt == 2'd2 |-> phase == tis_pkg::PH_HELD)
    else $error("two words pushed outside held phase");

  // An IAC between items or inside data is always held back
  a_iac_held: assert property (@(posedge clk) disable iff (rst)
    accept && byte_in == tis_pkg::CODE_IAC &&
    (phase == tis_pkg::PH_IDLE || phase == tis_pkg::PH_DATA)
    |=> phase == tis_pkg::PH_HELD && push.cnt == 2'd0 || phase == tis_pkg::PH_HELD)
    else $error("IAC not held back");

  // No word may be pushed without an accepted byte
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> accept)
    else $error("words pushed with no accepted byte");

endmodule

### sv/tis_out_queue.sv
// Four-word result queue: takes up to two words a cycle, gives at most one.
// Depends on tis_pkg.
// The head entry is the output register seen on the port.
module tis_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  tis_pkg::push_t   push,
  input  logic             pop,
  output tis_pkg::result_t head,
  output logic             not_empty,
  output logic             nearly_full
);

  tis_pkg::result_t mem [tis_pkg::QDEPTH];
  logic [tis_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [tis_pkg::QCNT_W-1:0] count, count_next;
  logic [tis_pkg::QPTR_W-1:0] wr_ptr_inc;

  assign wr_ptr_inc  = wr_ptr + tis_pkg::QPTR_W'(1);
  assign head        = mem[rd_ptr];
  assign not_empty   = count != '0;
  // room for a pair of words is kept at all times an input may arrive
  assign nearly_full = count > tis_pkg::QCNT_W'(tis_pkg::QDEPTH - 2);
  assign count_next  = count + {1'b0, push.cnt} - {{(tis_pkg::QCNT_W-1){1'b0}}, pop};

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_inc] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.cnt;
      if (pop) begin
        rd_ptr <= rd_ptr + tis_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= tis_pkg::QCNT_W'(tis_pkg::QDEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty result queue");

  a_pair_fill: assert property (@(posedge clk) disable iff (rst)
    push.cnt == 2'd2 && !pop |=> count == $past(count) + tis_pkg::QCNT_W'(2))
    else $error("fill count wrong after pair push");

endmodule

### tb/telnet_item_segmenter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for telnet_item_segmenter_unit: a directed table,
// then random item streams. Expected words come from a built-in model of the
// segmenter or from typed table rows. Depends on tis_pkg and the unit.
module telnet_item_segmenter_unit_tb;

  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 125;
  localparam tis_pkg::result_t NO_WORD = '0;

  // One row of the directed table
  typedef struct packed {
    logic [7:0]       val;
    logic             clr;
    logic             typed;
    logic [1:0]       n;
    tis_pkg::result_t w0;
    tis_pkg::result_t w1;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] byte_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] byte_out;
  logic       item_start;
  logic [1:0] item_kind;
  logic       last_of_run;

  // Segmenter model state and expected words
  tis_pkg::phase_t  seg_phase = tis_pkg::PH_IDLE;
  tis_pkg::kind_t   seg_kind = tis_pkg::KIND_DATA;
  logic             seg_drop = 1'b0;
  logic             seg_clear = 1'b0;
  tis_pkg::result_t expected_words [$];

  row_t directed [$];
  row_t cur_row = '0;
  logic in_quiet = 1'b0;
  logic out_quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   mismatches = 0;
  int   bytes_in = 0;
  int   bytes_sent = 0;
  int   words_checked = 0;
  int   cfg_writes = 0;
  int   idle_run = 0;

  telnet_item_segmenter_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_out   (byte_out),
    .item_start (item_start),
    .item_kind  (item_kind),
    .last_of_run(last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic tis_pkg::result_t mk_word(logic [7:0] v, logic s, tis_pkg::kind_t k,
                                               logic l);
    tis_pkg::result_t w;
    w.byte_val    = v;
    w.item_start  = s;
    w.item_kind   = k;
    w.last_of_run = l;
    return w;
  endfunction

  function automatic row_t pred_row(logic [7:0] v, logic clr);
    row_t r;
    r = '0;
    r.val = v;
    r.clr = clr;
    return r;
  endfunction

  function automatic row_t typed_row(logic [7:0] v, logic clr, logic [1:0] n,
                                     tis_pkg::result_t w0, tis_pkg::result_t w1);
    row_t r;
    r.val   = v;
    r.clr   = clr;
    r.typed = 1'b1;
    r.n     = n;
    r.w0    = w0;
    r.w1    = w1;
    return r;
  endfunction

  // Advances the model by one byte; returns how many words it gives
  function automatic int segment_byte(input logic [7:0] b, output tis_pkg::result_t w0,
                                      output tis_pkg::result_t w1);
    int n;
    n  = 0;
    w0 = NO_WORD;
    w1 = NO_WORD;
    case (seg_phase)
      tis_pkg::PH_HELD: begin
        if (b == tis_pkg::CODE_DO || b == tis_pkg::CODE_DONT ||
            b == tis_pkg::CODE_WILL || b == tis_pkg::CODE_WONT) begin
          seg_kind  = tis_pkg::KIND_NEG;
          seg_drop  = 1'b0;
          seg_phase = tis_pkg::PH_OPTION;
        end else if (b == tis_pkg::CODE_SB) begin
          seg_kind  = tis_pkg::KIND_SUB;
          seg_drop  = 1'b0;
          seg_phase = tis_pkg::PH_SUB;
        end else begin
          seg_kind  = tis_pkg::KIND_CMD;
          seg_drop  = seg_clear && (b == tis_pkg::CODE_EC || b == tis_pkg::CODE_EL);
          seg_phase = tis_pkg::PH_IDLE;
        end
        if (!seg_drop) begin
          w0 = mk_word(tis_pkg::CODE_IAC, 1'b1, seg_kind, 1'b0);
          w1 = mk_word(b, 1'b0, seg_kind, 1'b0);
          n  = 2;
        end
      end
      tis_pkg::PH_OPTION: begin
        w0 = mk_word(b, 1'b0, seg_kind, 1'b0);
        n  = 1;
        seg_phase = tis_pkg::PH_IDLE;
      end
      tis_pkg::PH_SUB: begin
        w0 = mk_word(b, 1'b0, seg_kind, 1'b0);
        n  = 1;
        if (b == tis_pkg::CODE_IAC) seg_phase = tis_pkg::PH_SUB_IAC;
      end
      tis_pkg::PH_SUB_IAC: begin
        w0 = mk_word(b, 1'b0, seg_kind, 1'b0);
        n  = 1;
        seg_phase = (b == tis_pkg::CODE_SE) ? tis_pkg::PH_IDLE : tis_pkg::PH_SUB;
      end
      tis_pkg::PH_DATA: begin
        if (b == tis_pkg::CODE_IAC) begin
          seg_phase = tis_pkg::PH_HELD;
        end else if (!seg_drop) begin
          w0 = mk_word(b, 1'b0, tis_pkg::KIND_DATA, 1'b0);
          n  = 1;
        end
      end
      default: begin
        if (b == tis_pkg::CODE_IAC) begin
          seg_phase = tis_pkg::PH_HELD;
        end else begin
          seg_kind  = tis_pkg::KIND_DATA;
          seg_drop  = seg_clear;
          seg_phase = tis_pkg::PH_DATA;
          if (!seg_drop) begin
            w0 = mk_word(b, 1'b1, tis_pkg::KIND_DATA, 1'b0);
            n  = 1;
          end
        end
      end
    endcase
    if (n == 1) w0.last_of_run = 1'b1;
    if (n == 2) w1.last_of_run = 1'b1;
    return n;
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Offers one byte after a random gap and returns at the negedge after it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      byte_in  = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    byte_in  = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  // synch_clear is written only once every expected word is out
  task automatic set_clear(input logic v);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes++;
  endtask

  // One random item: mostly well formed, some stray bytes
  task automatic send_item();
    int pick;
    int len;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      len = $urandom_range(1, 6);
      repeat (len) send_byte(8'($urandom_range(0, 8'hfe)));
    end else if (pick < 50) begin
      send_byte(tis_pkg::CODE_IAC);
      case ($urandom_range(0, 3))
        0: b = tis_pkg::CODE_EC;
        1: b = tis_pkg::CODE_EL;
        2: b = tis_pkg::CODE_IAC;
        default: b = 8'($urandom_range(0, 8'hf9));
      endcase
      send_byte(b);
    end else if (pick < 70) begin
      send_byte(tis_pkg::CODE_IAC);
      send_byte(8'($urandom_range(tis_pkg::CODE_WILL, tis_pkg::CODE_DONT)));
      send_byte(8'($urandom));
    end else if (pick < 90) begin
      send_byte(tis_pkg::CODE_IAC);
      send_byte(tis_pkg::CODE_SB);
      len = $urandom_range(0, 5);
      repeat (len) begin
        b = ($urandom_range(0, 5) == 0) ? tis_pkg::CODE_IAC : 8'($urandom_range(0, 8'hfe));
        send_byte(b);
        // escaped pair inside the subnegotiation, never IAC SE
        if (b == tis_pkg::CODE_IAC)
          send_byte(($urandom_range(0, 1) == 0) ? tis_pkg::CODE_IAC
                                                 : 8'($urandom_range(0, 8'hef)));
      end
      send_byte(tis_pkg::CODE_IAC);
      send_byte(tis_pkg::CODE_SE);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // Model update and output check, both at the rising edge
  always @(posedge clk) begin : monitor
    tis_pkg::result_t w0;
    tis_pkg::result_t w1;
    tis_pkg::result_t want;
    int n;
    if (rst) begin
      seg_phase = tis_pkg::PH_IDLE;
      seg_kind  = tis_pkg::KIND_DATA;
      seg_drop  = 1'b0;
      seg_clear = 1'b0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word with nothing expected: byte_out %0h start %0b kind %0d",
                   $time, byte_out, item_start, item_kind);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("byte_out", want.byte_val, byte_out);
          check_field("item_start", 8'(want.item_start), 8'(item_start));
          check_field("item_kind", 8'(want.item_kind), 8'(item_kind));
          check_field("last_of_run", 8'(want.last_of_run), 8'(last_of_run));
          words_checked++;
        end
      end
      if (cfg_we) seg_clear = cfg_wdata;
      if (in_valid && !in_stall) begin
        n = segment_byte(byte_in, w0, w1);
        if (cur_row.typed) begin
          n  = int'(cur_row.n);
          w0 = cur_row.w0;
          w1 = cur_row.w1;
        end
        if (n > 0) expected_words.push_back(w0);
        if (n > 1) expected_words.push_back(w1);
        bytes_in++;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int gap;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_stall = 1'b0;
      end else begin
        gap = pick_gap(out_quiet);
        out_stall = (gap != 0);
        if (gap > 1) repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  initial begin : watchdog
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("%0t: no progress for %0d cycles, %0d words still expected",
             $time, IDLE_LIMIT, expected_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int start;
    // clear off: data start after reset, negotiation, subnegotiation with escape, EC kept
    directed.push_back(typed_row(8'h00, 1'b0, 2'd1,
                                 mk_word(8'h00, 1'b1, tis_pkg::KIND_DATA, 1'b1), NO_WORD));
    directed.push_back(pred_row(8'hfe, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_DO, 1'b0));
    directed.push_back(pred_row(8'h01, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_SB, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_SE, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b0));
    directed.push_back(pred_row(tis_pkg::CODE_EC, 1'b0));
    directed.push_back(pred_row(8'h41, 1'b0));
    // clear on mid-run: the open data run stays kept
    directed.push_back(pred_row(8'h42, 1'b1));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b1));
    directed.push_back(typed_row(tis_pkg::CODE_EL, 1'b1, 2'd0, NO_WORD, NO_WORD));
    directed.push_back(typed_row(8'h7f, 1'b1, 2'd0, NO_WORD, NO_WORD));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b1));
    directed.push_back(typed_row(tis_pkg::CODE_IAC, 1'b1, 2'd2,
                                 mk_word(tis_pkg::CODE_IAC, 1'b1, tis_pkg::KIND_CMD, 1'b0),
                                 mk_word(tis_pkg::CODE_IAC, 1'b0, tis_pkg::KIND_CMD, 1'b1)));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b1));
    directed.push_back(pred_row(tis_pkg::CODE_WILL, 1'b1));
    directed.push_back(pred_row(8'hff, 1'b1));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b1));
    directed.push_back(pred_row(tis_pkg::CODE_DONT, 1'b1));
    directed.push_back(pred_row(8'h00, 1'b1));
    directed.push_back(pred_row(tis_pkg::CODE_IAC, 1'b1));
    directed.push_back(pred_row(tis_pkg::CODE_WONT, 1'b1));
    directed.push_back(pred_row(8'h80, 1'b1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_clear(1'b0);

    foreach (directed[i]) begin
      if (directed[i].clr != seg_clear) set_clear(directed[i].clr);
      cur_row = directed[i];
      send_byte(directed[i].val);
    end
    cur_row = '0;

    // Random phases, alternating synch_clear; one long receiver hold, some quiet stretches
    for (int p = 0; p < PHASES; p++) begin
      set_clear(p[0]);
      in_quiet  = (p == 3 || p == 5);
      out_quiet = (p == 4 || p == 5);
      if (p == 1) hold_req = 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_item();
    end

    in_valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d bytes (%0d from the directed table), %0d synch_clear writes.",
             bytes_in, directed.size(), cfg_writes);
    $display("Checked %0d output words across data, command, negotiation and subneg items.",
             words_checked);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### telnet_item_segmenter_unit.f
sv/tis_pkg.sv
sv/tis_parser.sv
sv/tis_out_queue.sv
sv/telnet_item_segmenter_unit.sv
tb/telnet_item_segmenter_unit_tb.sv
